@@ design/hdhc_pkg.sv @@
// Shared types, codes and reset values of the heading and depth hold controller.
`default_nettype none

package hdhc_pkg;

   // Field widths of the request and response channels
   localparam int CMD_W    = 3;
   localparam int TARGET_W = 16;
   localparam int HDG_W    = 9;
   localparam int DEPTH_W  = 16;
   localparam int DRIVE_W  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int GAIN_W     = 12;
   localparam int DBAND_W    = 8;
   localparam int LIMIT_W    = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_GAIN   = 3'd0,
      CSR_HEADING_GAIN = 3'd1,
      CSR_DEPTH_DBAND  = 3'd2,
      CSR_HEADING_DBAND = 3'd3,
      CSR_LIFT_LIMIT   = 3'd4,
      CSR_YAW_LIMIT    = 3'd5
   } csr_index_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_HEADING_ON  = 3'd1,
      CMD_HEADING_OFF = 3'd2,
      CMD_HEADING_TGL = 3'd3,
      CMD_DEPTH_ON    = 3'd4,
      CMD_DEPTH_OFF   = 3'd5,
      CMD_DEPTH_TGL   = 3'd6
   } cmd_type;

   localparam logic AXIS_LIFT = 1'b0;
   localparam logic AXIS_YAW  = 1'b1;

   // Register reset values
   localparam logic [GAIN_W-1:0]  DEPTH_GAIN_RST    = 12'd154;
   localparam logic [GAIN_W-1:0]  HEADING_GAIN_RST  = 12'd256;
   localparam logic [DBAND_W-1:0] DEPTH_DBAND_RST   = 8'd4;
   localparam logic [DBAND_W-1:0] HEADING_DBAND_RST = 8'd4;
   localparam logic [LIMIT_W-1:0] LIFT_LIMIT_RST    = 7'd100;
   localparam logic [LIMIT_W-1:0] YAW_LIMIT_RST     = 7'd50;

   // Heading wrap bounds, on the 18 bit signed error
   localparam logic signed [17:0] HDG_WRAP_HI = 18'sd180;
   localparam logic signed [17:0] HDG_WRAP_LO = -18'sd179;
   localparam logic signed [17:0] HDG_TURN    = 18'sd360;

   typedef struct packed {
      logic                      axis;
      logic signed [DRIVE_W-1:0] drive;
      logic                      last;
   } rsp_item_type;

   // mag * gain / 256 truncated, clamped to limit, sign applied afterwards
   function automatic logic signed [DRIVE_W-1:0] scale_clamp(
      input logic [16:0]        mag,
      input logic               neg,
      input logic [GAIN_W-1:0]  gain,
      input logic [LIMIT_W-1:0] limit
   );
      logic [28:0]        prod;
      logic [20:0]        quot;
      logic [LIMIT_W-1:0] sat;
      logic [DRIVE_W-1:0] pos;
      prod = mag * gain;
      quot = prod[28:8];
      sat  = (quot > 21'(limit)) ? limit : quot[LIMIT_W-1:0];
      pos  = {1'b0, sat};
      return neg ? $signed(-pos) : $signed(pos);
   endfunction

endpackage

`default_nettype wire

@@ design/hdhc_if.sv @@
// Request and response channel interfaces of the heading and depth hold controller.
`default_nettype none

interface hdhc_req_if;
   import hdhc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic                       use_given_target;
   logic signed [TARGET_W-1:0] given_target;
   logic [HDG_W-1:0]           measured_heading;
   logic signed [DEPTH_W-1:0]  measured_depth_cm;

   modport source(output valid, command, use_given_target, given_target,
                  measured_heading, measured_depth_cm, input ready);
   modport sink(input valid, command, use_given_target, given_target,
                measured_heading, measured_depth_cm, output ready);
endinterface

interface hdhc_rsp_if;
   import hdhc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      axis;
   logic signed [DRIVE_W-1:0] drive;
   logic                      last;

   modport source(output valid, axis, drive, last, input ready);
   modport sink(input valid, axis, drive, last, output ready);
endinterface

`default_nettype wire

@@ design/heading_depth_hold_controller.sv @@
// Depth and heading proportional hold controller with deadband and clamp.
//
//  channel   direction  handshake        payload
//  req_chan  in         valid / ready    command, use_given_target, given_target,
//                                        measured_heading, measured_depth_cm
//  rsp_chan  out        valid / ready    axis, drive, last
//  csr_*     in         csr_we, no wait  csr_index, csr_wdata
//
// A request is registered at the edge that accepts it; its responses are computed
// from that register and land in a two-entry response buffer once it is free.
// The rate is one request per cycle for zero responses, and for one response
// while the response side takes every response; a request with two responses
// keeps the buffer until both are taken, and the next request with responses waits.
// Reset is synchronous and active high; it restores register defaults and drops
// both holds. A stalled response side holds the request register and lowers
// req_chan.ready; nothing is lost.
`default_nettype none

module heading_depth_hold_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   hdhc_req_if.sink                            req_chan,
   hdhc_rsp_if.source                          rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [hdhc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [hdhc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hdhc_pkg::*;

   // ---------------- configuration registers ----------------
   logic [GAIN_W-1:0]  depth_gain_ff, depth_gain_in;
   logic [GAIN_W-1:0]  heading_gain_ff, heading_gain_in;
   logic [DBAND_W-1:0] depth_dband_ff, depth_dband_in;
   logic [DBAND_W-1:0] heading_dband_ff, heading_dband_in;
   logic [LIMIT_W-1:0] lift_limit_ff, lift_limit_in;
   logic [LIMIT_W-1:0] yaw_limit_ff, yaw_limit_in;

   always_comb begin
      depth_gain_in    = depth_gain_ff;
      heading_gain_in  = heading_gain_ff;
      depth_dband_in   = depth_dband_ff;
      heading_dband_in = heading_dband_ff;
      lift_limit_in    = lift_limit_ff;
      yaw_limit_in     = yaw_limit_ff;
      if (csr_we) begin
         // Indexes past the list fall into the default arm and are dropped
         unique case (csr_index_type'(csr_index))
            CSR_DEPTH_GAIN:    depth_gain_in    = csr_wdata[GAIN_W-1:0];
            CSR_HEADING_GAIN:  heading_gain_in  = csr_wdata[GAIN_W-1:0];
            CSR_DEPTH_DBAND:   depth_dband_in   = csr_wdata[DBAND_W-1:0];
            CSR_HEADING_DBAND: heading_dband_in = csr_wdata[DBAND_W-1:0];
            CSR_LIFT_LIMIT:    lift_limit_in    = csr_wdata[LIMIT_W-1:0];
            CSR_YAW_LIMIT:     yaw_limit_in     = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_gain_ff    <= DEPTH_GAIN_RST;
         heading_gain_ff  <= HEADING_GAIN_RST;
         depth_dband_ff   <= DEPTH_DBAND_RST;
         heading_dband_ff <= HEADING_DBAND_RST;
         lift_limit_ff    <= LIFT_LIMIT_RST;
         yaw_limit_ff     <= YAW_LIMIT_RST;
      end else begin
         depth_gain_ff    <= depth_gain_in;
         heading_gain_ff  <= heading_gain_in;
         depth_dband_ff   <= depth_dband_in;
         heading_dband_ff <= heading_dband_in;
         lift_limit_ff    <= lift_limit_in;
         yaw_limit_ff     <= yaw_limit_in;
      end
   end

   // ---------------- handshake control ----------------
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_count;
   logic       s1_advance;
   logic       buf_free;
   logic [1:0] buf_cnt_ff, buf_cnt_in;
   logic       req_fire, rsp_fire;

   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   // The buffer takes a new pair once it is empty or loses its final entry now
   assign buf_free   = (buf_cnt_ff == 2'd0) || ((buf_cnt_ff == 2'd1) && rsp_fire);
   // A request with no responses retires without touching the buffer
   assign s1_advance = (s1_count == 2'd0) || buf_free;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   // ---------------- hold state, updated at acceptance ----------------
   logic                       heading_on_ff, heading_on_in;
   logic                       depth_on_ff, depth_on_in;
   logic signed [TARGET_W-1:0] heading_target_ff, heading_target_in;
   logic signed [TARGET_W-1:0] depth_target_ff, depth_target_in;

   // Per-request snapshot carried into the compute register
   logic                       s1_lift_ff, s1_lift_in;     // emit a lift response
   logic                       s1_yaw_ff, s1_yaw_in;       // emit a yaw response
   logic                       s1_lift_run_ff, s1_lift_run_in; // computed, not forced zero
   logic                       s1_yaw_run_ff, s1_yaw_run_in;
   logic signed [TARGET_W-1:0] s1_dtarget_ff, s1_dtarget_in;
   logic signed [TARGET_W-1:0] s1_htarget_ff, s1_htarget_in;
   logic signed [DEPTH_W-1:0]  s1_depth_ff, s1_depth_in;
   logic [HDG_W-1:0]           s1_heading_ff, s1_heading_in;

   cmd_type cmd_raw;
   cmd_type cmd_eff;

   assign cmd_raw = cmd_type'(req_chan.command);

   always_comb begin
      // Resolve toggles against the current hold state
      case (cmd_raw)
         CMD_HEADING_TGL: cmd_eff = heading_on_ff ? CMD_HEADING_OFF : CMD_HEADING_ON;
         CMD_DEPTH_TGL:   cmd_eff = depth_on_ff ? CMD_DEPTH_OFF : CMD_DEPTH_ON;
         default:         cmd_eff = cmd_raw;
      endcase
   end

   always_comb begin
      heading_on_in     = heading_on_ff;
      depth_on_in       = depth_on_ff;
      heading_target_in = heading_target_ff;
      depth_target_in   = depth_target_ff;
      s1_valid_in       = s1_valid_ff && !s1_advance;
      s1_lift_in        = s1_lift_ff;
      s1_yaw_in         = s1_yaw_ff;
      s1_lift_run_in    = s1_lift_run_ff;
      s1_yaw_run_in     = s1_yaw_run_ff;
      s1_dtarget_in     = s1_dtarget_ff;
      s1_htarget_in     = s1_htarget_ff;
      s1_depth_in       = s1_depth_ff;
      s1_heading_in     = s1_heading_ff;
      if (req_fire) begin
         s1_valid_in    = 1'b1;
         s1_lift_in     = 1'b0;
         s1_yaw_in      = 1'b0;
         s1_lift_run_in = 1'b0;
         s1_yaw_run_in  = 1'b0;
         s1_dtarget_in  = depth_target_ff;
         s1_htarget_in  = heading_target_ff;
         s1_depth_in    = req_chan.measured_depth_cm;
         s1_heading_in  = req_chan.measured_heading;
         unique case (cmd_eff)
            CMD_TICK: begin
               s1_lift_in     = depth_on_ff;
               s1_yaw_in      = heading_on_ff;
               s1_lift_run_in = 1'b1;
               s1_yaw_run_in  = 1'b1;
            end
            CMD_HEADING_ON: begin
               heading_on_in     = 1'b1;
               heading_target_in = req_chan.use_given_target ? req_chan.given_target
                                 : $signed({{(TARGET_W-HDG_W){1'b0}},
                                            req_chan.measured_heading});
            end
            CMD_HEADING_OFF: begin
               heading_on_in = 1'b0;
               s1_yaw_in     = 1'b1;
            end
            CMD_DEPTH_ON: begin
               depth_on_in     = 1'b1;
               depth_target_in = req_chan.use_given_target ? req_chan.given_target
                               : req_chan.measured_depth_cm;
            end
            CMD_DEPTH_OFF: begin
               depth_on_in = 1'b0;
               s1_lift_in  = 1'b1;
            end
            default: ; // unused code: no response, state unchanged
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_on_ff     <= 1'b0;
         depth_on_ff       <= 1'b0;
         heading_target_ff <= '0;
         depth_target_ff   <= '0;
         s1_valid_ff       <= 1'b0;
         s1_lift_ff        <= 1'b0;
         s1_yaw_ff         <= 1'b0;
      end else begin
         heading_on_ff     <= heading_on_in;
         depth_on_ff       <= depth_on_in;
         heading_target_ff <= heading_target_in;
         depth_target_ff   <= depth_target_in;
         s1_valid_ff       <= s1_valid_in;
         s1_lift_ff        <= s1_lift_in;
         s1_yaw_ff         <= s1_yaw_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_lift_run_ff <= s1_lift_run_in;
      s1_yaw_run_ff  <= s1_yaw_run_in;
      s1_dtarget_ff  <= s1_dtarget_in;
      s1_htarget_ff  <= s1_htarget_in;
      s1_depth_ff    <= s1_depth_in;
      s1_heading_ff  <= s1_heading_in;
   end

   // ---------------- drive computation ----------------
   logic signed [16:0]        d_err;
   logic [16:0]               d_mag;
   logic signed [DRIVE_W-1:0] d_drive;
   logic signed [17:0]        h_raw, h_wrap1, h_err;
   logic [17:0]               h_mag_full;
   logic [16:0]               h_mag;
   logic signed [DRIVE_W-1:0] h_drive;

   always_comb begin
      // Depth: error = target - measured; positive error drives lift up
      d_err = 17'(s1_dtarget_ff) - 17'(s1_depth_ff);
      d_mag = d_err[16] ? 17'(-d_err) : 17'(d_err);
      if (!s1_lift_run_ff || (d_mag <= 17'(depth_dband_ff))) begin
         d_drive = '0;
      end else begin
         d_drive = scale_clamp(d_mag, d_err[16], depth_gain_ff, lift_limit_ff);
      end

      // Heading: error = measured - target, wrapped once each way; yaw opposes it
      h_raw   = $signed({9'b0, s1_heading_ff}) - 18'(s1_htarget_ff);
      h_wrap1 = (h_raw > HDG_WRAP_HI) ? h_raw - HDG_TURN : h_raw;
      h_err   = (h_wrap1 < HDG_WRAP_LO) ? h_wrap1 + HDG_TURN : h_wrap1;
      h_mag_full = h_err[17] ? 18'(-h_err) : 18'(h_err);
      h_mag   = h_mag_full[16:0];
      if (!s1_yaw_run_ff || (h_mag <= 17'(heading_dband_ff))) begin
         h_drive = '0;
      end else begin
         h_drive = scale_clamp(h_mag, !h_err[17], heading_gain_ff, yaw_limit_ff);
      end
   end

   // Order responses: lift first, then yaw; the final one carries last
   rsp_item_type r0, r1;

   assign s1_count = s1_valid_ff ? (2'(s1_lift_ff) + 2'(s1_yaw_ff)) : 2'd0;

   always_comb begin
      r0.axis  = s1_lift_ff ? AXIS_LIFT : AXIS_YAW;
      r0.drive = s1_lift_ff ? d_drive : h_drive;
      r0.last  = (s1_count == 2'd1);
      r1.axis  = AXIS_YAW;
      r1.drive = h_drive;
      r1.last  = 1'b1;
   end

   // ---------------- response buffer ----------------
   rsp_item_type slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic         buf_load;

   assign buf_load = s1_valid_ff && (s1_count != 2'd0) && buf_free;

   always_comb begin
      buf_cnt_in = buf_cnt_ff;
      slot0_in   = slot0_ff;
      slot1_in   = slot1_ff;
      if (buf_load) begin
         // The buffer is empty after this edge's pop, so refill from the head
         slot0_in   = r0;
         slot1_in   = r1;
         buf_cnt_in = s1_count;
      end else if (rsp_fire) begin
         slot0_in   = slot1_ff;
         buf_cnt_in = buf_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= 2'd0;
      end else begin
         buf_cnt_ff <= buf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid = (buf_cnt_ff != 2'd0);
   assign rsp_chan.axis  = slot0_ff.axis;
   assign rsp_chan.drive = slot0_ff.drive;
   assign rsp_chan.last  = slot0_ff.last;

   // ---------------- assertions ----------------
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      buf_cnt_ff != 2'd3)
      else $error("response buffer count out of range");

   a_head_not_last: assert property (@(posedge clock) disable iff (reset)
      (buf_cnt_ff == 2'd2) |-> !slot0_ff.last)
      else $error("first of a response pair marked last");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_lift_ff)
                                        && $stable(s1_yaw_ff)))
      else $error("stalled request lost");

   a_heading_off: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd_eff == CMD_HEADING_OFF)) |=> (!heading_on_ff && s1_yaw_ff))
      else $error("heading off did not drop hold or queue zero yaw");

   a_depth_on: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (cmd_eff == CMD_DEPTH_ON)) |=> (depth_on_ff && !s1_lift_ff))
      else $error("depth on did not set hold silently");

endmodule

`default_nettype wire

@@ sim/heading_depth_hold_controller_checker.sv @@
// Checker that predicts the drive responses of the hold controller and compares them.
`default_nettype none

module heading_depth_hold_controller_checker
   import hdhc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   hdhc_req_if                        req_chan,
   hdhc_rsp_if                        rsp_chan,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         drives_pending
);

   logic [GAIN_W-1:0]  depth_gain, heading_gain;
   logic [DBAND_W-1:0] depth_dband, heading_dband;
   logic [LIMIT_W-1:0] lift_lim, yaw_lim;

   logic                       depth_hold, heading_hold;
   logic signed [TARGET_W-1:0] depth_goal, heading_goal;

   rsp_item_type expected_drives[$];

   // err * gain / 256 toward zero, clamp, then zero inside the deadband
   function automatic logic signed [DRIVE_W-1:0] proportional_drive(
      longint err, longint gain, longint limit, longint deadband);
      longint mag;
      longint level;
      mag   = (err < 0) ? -err : err;
      level = (mag * gain) / 256;
      if (level > limit) level = limit;
      if (mag <= deadband) level = 0;
      return (err < 0) ? DRIVE_W'(-level) : DRIVE_W'(level);
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   task automatic predict_drives();
      logic [CMD_W-1:0] op;
      rsp_item_type     item;
      int               err;
      int               base;
      op   = req_chan.command;
      base = expected_drives.size();
      if (op == CMD_HEADING_TGL) op = heading_hold ? CMD_HEADING_OFF : CMD_HEADING_ON;
      if (op == CMD_DEPTH_TGL) op = depth_hold ? CMD_DEPTH_OFF : CMD_DEPTH_ON;
      case (op)
         CMD_TICK: begin
            if (depth_hold) begin
               err = int'(depth_goal) - int'(req_chan.measured_depth_cm);
               item = '{AXIS_LIFT, proportional_drive(err, depth_gain, lift_lim, depth_dband),
                        1'b0};
               expected_drives.push_back(item);
            end
            if (heading_hold) begin
               err = int'(req_chan.measured_heading) - int'(heading_goal);
               // wrap once each way, no more
               if (err > 180) err -= 360;
               if (err < -179) err += 360;
               item = '{AXIS_YAW, proportional_drive(-err, heading_gain, yaw_lim, heading_dband),
                        1'b0};
               expected_drives.push_back(item);
            end
         end
         CMD_HEADING_ON: begin
            heading_hold = 1'b1;
            heading_goal = req_chan.use_given_target ? req_chan.given_target
                                                     : TARGET_W'(req_chan.measured_heading);
         end
         CMD_HEADING_OFF: begin
            heading_hold = 1'b0;
            item = '{AXIS_YAW, DRIVE_W'(0), 1'b0};
            expected_drives.push_back(item);
         end
         CMD_DEPTH_ON: begin
            depth_hold = 1'b1;
            depth_goal = req_chan.use_given_target ? req_chan.given_target
                                                   : req_chan.measured_depth_cm;
         end
         CMD_DEPTH_OFF: begin
            depth_hold = 1'b0;
            item = '{AXIS_LIFT, DRIVE_W'(0), 1'b0};
            expected_drives.push_back(item);
         end
         default: ;
      endcase
      if (expected_drives.size() > base) begin
         item = expected_drives.pop_back();
         item.last = 1'b1;
         expected_drives.push_back(item);
      end
   endtask

   task automatic check_drive();
      rsp_item_type want;
      if (expected_drives.size() == 0) begin
         report_mismatch($sformatf("unexpected drive axis %0d value %0d last %0d",
                                   rsp_chan.axis, rsp_chan.drive, rsp_chan.last));
      end else begin
         want = expected_drives.pop_front();
         if (rsp_chan.axis !== want.axis)
            report_mismatch($sformatf("axis %0d, wanted %0d", rsp_chan.axis, want.axis));
         if (rsp_chan.drive !== want.drive)
            report_mismatch($sformatf("drive %0d, wanted %0d on axis %0d",
                                      rsp_chan.drive, want.drive, want.axis));
         if (rsp_chan.last !== want.last)
            report_mismatch($sformatf("last %0d, wanted %0d", rsp_chan.last, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         depth_gain    = DEPTH_GAIN_RST;
         heading_gain  = HEADING_GAIN_RST;
         depth_dband   = DEPTH_DBAND_RST;
         heading_dband = HEADING_DBAND_RST;
         lift_lim      = LIFT_LIMIT_RST;
         yaw_lim       = YAW_LIMIT_RST;
         depth_hold    = 1'b0;
         heading_hold  = 1'b0;
         depth_goal    = '0;
         heading_goal  = '0;
         expected_drives.delete();
      end else begin
         // compare first so a stray response never matches this edge's request
         if (rsp_chan.valid && rsp_chan.ready) check_drive();
         if (req_chan.valid && req_chan.ready) predict_drives();
         if (csr_we) begin
            case (csr_index)
               CSR_DEPTH_GAIN:    depth_gain    = csr_wdata[GAIN_W-1:0];
               CSR_HEADING_GAIN:  heading_gain  = csr_wdata[GAIN_W-1:0];
               CSR_DEPTH_DBAND:   depth_dband   = csr_wdata[DBAND_W-1:0];
               CSR_HEADING_DBAND: heading_dband = csr_wdata[DBAND_W-1:0];
               CSR_LIFT_LIMIT:    lift_lim      = csr_wdata[LIMIT_W-1:0];
               CSR_YAW_LIMIT:     yaw_lim       = csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
      drives_pending = expected_drives.size();
   end

endmodule

`default_nettype wire

@@ sim/heading_depth_hold_controller_test.sv @@
// Top of the hold controller testbench: clock, reset, stimulus and verdict.
`default_nettype none

module heading_depth_hold_controller_test;
   import hdhc_pkg::*;

   // No request or response moves for this many cycles: give up
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to let the request and response registers empty out
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 250;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hdhc_req_if req_chan();
   hdhc_rsp_if rsp_chan();

   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int drives_pending;

   // when set, neither side idles
   bit steady_flow;
   int idle_cycles;
   int stall_left;
   // rough depth the vehicle sits at; keeps errors near the deadband often
   logic signed [DEPTH_W-1:0] depth_base;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   heading_depth_hold_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   heading_depth_hold_controller_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .drives_pending (drives_pending)
   );

   // Idle length for either side: mostly none, some short, a few long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_flow || pick < 60) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Response side: hold ready low for random stalls
   initial begin
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = idle_length();
         end
      end
   end

   // Watchdog: any handshake or register write restarts the count
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request, hold it until accepted, then maybe idle
   task automatic send_request(logic [CMD_W-1:0] cmd, logic use_given,
                               logic signed [TARGET_W-1:0] given, logic [HDG_W-1:0] hdg,
                               logic signed [DEPTH_W-1:0] dep);
      int gap;
      req_chan.valid             <= 1'b1;
      req_chan.command           <= cmd;
      req_chan.use_given_target  <= use_given;
      req_chan.given_target      <= given;
      req_chan.measured_heading  <= hdg;
      req_chan.measured_depth_cm <= dep;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = idle_length();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected drive has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
   endtask

   task automatic load_settings(int depth_gain, int heading_gain, int depth_dband,
                                int heading_dband, int lift_lim, int yaw_lim);
      write_register(CSR_DEPTH_GAIN, depth_gain);
      write_register(CSR_HEADING_GAIN, heading_gain);
      write_register(CSR_DEPTH_DBAND, depth_dband);
      write_register(CSR_HEADING_DBAND, heading_dband);
      write_register(CSR_LIFT_LIMIT, lift_lim);
      write_register(CSR_YAW_LIMIT, yaw_lim);
      csr_we <= 1'b0;
   endtask

   // One random request, weighted toward ticks with holds engaged
   task automatic random_request();
      int                         pick;
      logic [CMD_W-1:0]           cmd;
      logic signed [TARGET_W-1:0] given;
      logic [HDG_W-1:0]           hdg;
      logic signed [DEPTH_W-1:0]  dep;
      pick = $urandom_range(0, 99);
      if (pick < 55)      cmd = CMD_TICK;
      else if (pick < 63) cmd = CMD_HEADING_ON;
      else if (pick < 67) cmd = CMD_HEADING_OFF;
      else if (pick < 73) cmd = CMD_HEADING_TGL;
      else if (pick < 81) cmd = CMD_DEPTH_ON;
      else if (pick < 85) cmd = CMD_DEPTH_OFF;
      else if (pick < 91) cmd = CMD_DEPTH_TGL;
      else if (pick < 94) cmd = CMD_UNUSED;
      else                cmd = CMD_W'($urandom_range(0, 7));

      // move the vehicle now and then
      if ($urandom_range(0, 49) == 0) depth_base = DEPTH_W'(int'($urandom_range(0, 8000)) - 4000);

      if ($urandom_range(0, 9) == 0) hdg = HDG_W'($urandom_range(360, 511));
      else                           hdg = HDG_W'($urandom_range(0, 359));

      if ($urandom_range(0, 7) == 0) dep = DEPTH_W'($urandom);
      else dep = depth_base + DEPTH_W'(int'($urandom_range(0, 400)) - 200);

      if ($urandom_range(0, 5) == 0)
         given = TARGET_W'($urandom);
      else if (cmd == CMD_HEADING_ON || cmd == CMD_HEADING_TGL)
         given = TARGET_W'($urandom_range(0, 359));
      else
         given = depth_base + TARGET_W'(int'($urandom_range(0, 200)) - 100);

      send_request(cmd, 1'($urandom_range(0, 1)), given, hdg, dep);
   endtask

   initial begin
      req_chan.valid             <= 1'b0;
      req_chan.command           <= CMD_TICK;
      req_chan.use_given_target  <= 1'b0;
      req_chan.given_target      <= '0;
      req_chan.measured_heading  <= '0;
      req_chan.measured_depth_cm <= '0;
      csr_we                     <= 1'b0;
      csr_index                  <= CSR_DEPTH_GAIN;
      csr_wdata                  <= '0;
      steady_flow = 1'b0;
      depth_base  = 16'sd1000;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, no holds yet, so nothing comes back
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, 16'sd0);
      send_request(CMD_UNUSED, 1'b1, 16'sd77, 9'd90, 16'sd5);
      // capture depth from the measurement, then walk across the deadband
      send_request(CMD_DEPTH_ON, 1'b0, 16'sd500, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, 16'sd1004);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, 16'sd1005);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, -16'sd32768);
      // heading on a given target; ticks now give lift then yaw
      send_request(CMD_HEADING_ON, 1'b1, 16'sd350, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd10, 16'sd990);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd511, 16'sd1000);
      // toggle off then on, capturing heading 0; then wrap from above 180
      send_request(CMD_HEADING_TGL, 1'b0, 16'sd0, 9'd45, 16'sd1000);
      send_request(CMD_HEADING_TGL, 1'b0, 16'sd123, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd181, 16'sd1000);
      // extreme targets leave the error outside the wrap window
      send_request(CMD_HEADING_ON, 1'b1, -16'sd32768, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd359, 16'sd1000);
      send_request(CMD_HEADING_ON, 1'b1, 16'sd32767, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd0, 16'sd1000);
      send_request(CMD_DEPTH_OFF, 1'b0, 16'sd0, 9'd0, 16'sd1000);
      send_request(CMD_DEPTH_TGL, 1'b1, 16'sd32767, 9'd0, 16'sd1000);
      send_request(CMD_TICK, 1'b0, 16'sd0, 9'd256, -16'sd32768);
      send_request(CMD_DEPTH_TGL, 1'b0, 16'sd0, 9'd0, 16'sd0);
      send_request(CMD_HEADING_OFF, 1'b0, 16'sd0, 9'd0, 16'sd0);
      // switching off an idle hold still answers with a zero drive
      send_request(CMD_HEADING_OFF, 1'b0, 16'sd0, 9'd0, 16'sd0);
      send_request(CMD_DEPTH_OFF, 1'b0, 16'sd0, 9'd0, 16'sd0);

      // Random phases, each under its own register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: ; // keep the reset settings
            1: load_settings(4095, 4095, 255, 255, 127, 127);
            2: load_settings(0, 0, 0, 0, 0, 0);
            3: load_settings(256, 4095, 0, 0, 127, 127);
            default: load_settings($urandom_range(0, 1200), $urandom_range(0, 1200),
                                   $urandom_range(0, 40), $urandom_range(0, 40),
                                   $urandom_range(1, 127), $urandom_range(1, 127));
         endcase
         steady_flow = (phase == 3 || phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) random_request();
      end

      settle();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
